### hdl/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the first expression holds, the second must hold at the following clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/wdr_pkg.sv
package wdr_pkg;

   localparam int MAX_SCALE  = 28;
   localparam int MANT_W     = 224;
   localparam int RES_W      = 96;
   localparam int HALF_W     = 16;
   localparam int HALF_COUNT = MANT_W / HALF_W;
   localparam int SCALE_W    = 10;
   localparam int CUR_W      = HALF_W + 4;
   localparam int PROD_W     = 2 * CUR_W;
   localparam int DIV_SHIFT  = 23;
   localparam logic [CUR_W-1:0] DIV_MAGIC = CUR_W'(838861);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_POS_OVF = 2'd1;
   localparam logic [1:0] STATUS_NEG_OVF = 2'd2;

   typedef struct packed {
      logic [31:0] mant_word0;
      logic [31:0] mant_word1;
      logic [31:0] mant_word2;
      logic [31:0] mant_word3;
      logic [31:0] mant_word4;
      logic [31:0] mant_word5;
      logic [31:0] mant_word6;
      logic [7:0]  in_scale;
      logic        in_sign;
   } req_type;

   typedef struct packed {
      logic [31:0] res_low;
      logic [31:0] res_mid;
      logic [31:0] res_high;
      logic [4:0]  res_scale;
      logic        res_sign;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic loop_go;
      logic out_free;
   } stat_type;

endpackage

### hdl/wdr_ctrl.sv
module wdr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wdr_pkg::stat_type stat,
   output wdr_pkg::cmd_type  cmd
);
   import wdr_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic       last;

   assign last = (count_ff == 4'(HALF_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = stat.loop_go ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            if (last) state_in = ST_TEST;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_TEST: begin
            count_in = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = last;
            count_in     = count_ff + 4'd1;
         end
         ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/wdr_datapath.sv
module wdr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  wdr_pkg::req_type  req_data,
   input  wdr_pkg::cmd_type  cmd,
   output wdr_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wdr_pkg::rsp_type  rsp_data
);
   import wdr_pkg::*;

   logic [MANT_W-1:0]         w_ff;
   logic [3:0]                rem_ff;
   logic signed [SCALE_W-1:0] scale_ff;
   logic                      sign_ff, rnd_ff, sticky_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff;

   logic [CUR_W-1:0]  cur, q10;
   logic [PROD_W-1:0] prod;
   logic [HALF_W-1:0] q;
   logic [3:0]        rem_new;
   logic              zero, upper, eqmax, rnd_new;
   logic [RES_W-1:0]  sum;

   assign cur     = {rem_ff, w_ff[MANT_W-1 -: HALF_W]};
   assign prod    = cur * DIV_MAGIC;
   assign q       = prod[DIV_SHIFT +: HALF_W];
   assign q10     = ({4'b0, q} << 3) + ({4'b0, q} << 1);
   assign rem_new = 4'(cur - q10);
   assign rnd_new = (rem_new > 4'd5) || ((rem_new == 4'd5) && (sticky_ff || q[0]));

   assign zero  = (w_ff == '0);
   assign upper = |w_ff[MANT_W-1:RES_W];
   assign eqmax = !upper && (w_ff[RES_W-1:0] == '1);

   assign stat.loop_go  = (!zero || rnd_ff) &&
                          (upper || (eqmax && rnd_ff) ||
                           (scale_ff > $signed(SCALE_W'(MAX_SCALE))));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign sum = w_ff[RES_W-1:0] + RES_W'(rnd_ff);

   always_comb begin
      rsp_in = '0;
      if (scale_ff < 0) begin
         rsp_in.status = sign_ff ? STATUS_NEG_OVF : STATUS_POS_OVF;
      end else if (sum != '0) begin
         rsp_in.res_low   = sum[31:0];
         rsp_in.res_mid   = sum[63:32];
         rsp_in.res_high  = sum[95:64];
         rsp_in.res_scale = scale_ff[4:0];
         rsp_in.res_sign  = sign_ff;
         rsp_in.status    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff      <= {req_data.mant_word6, req_data.mant_word5, req_data.mant_word4,
                       req_data.mant_word3, req_data.mant_word2, req_data.mant_word1,
                       req_data.mant_word0};
         rem_ff    <= '0;
         scale_ff  <= $signed({2'b0, req_data.in_scale});
         sign_ff   <= req_data.in_sign;
         rnd_ff    <= 1'b0;
         sticky_ff <= 1'b0;
      end else if (cmd.div_step) begin
         w_ff   <= {w_ff[MANT_W-HALF_W-1:0], q};
         rem_ff <= rem_new;
         if (cmd.div_last) begin
            rem_ff    <= '0;
            scale_ff  <= scale_ff - SCALE_W'(1);
            rnd_ff    <= rnd_new;
            sticky_ff <= sticky_ff || (rem_new != 4'd0);
         end
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/wide_decimal_round_to_96bit.sv
// A result follows acceptance after n divide-by-ten passes (0 to 68); each pass is
// a test state followed by one division step per 16-bit digit, fourteen digits in all.
// One transaction is processed at a time, and the finish step waits while a stalled result
// is held; a new transaction is accepted while a result still waits.
// Reset is synchronous and active high; it clears the controller and output valid.
module wide_decimal_round_to_96bit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wdr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wdr_pkg::rsp_type rsp_data
);
   import wdr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wdr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/wdr_checker.sv
`include "assert_macros.svh"

module wdr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wdr_pkg::rsp_type rsp_data
);
   import wdr_pkg::*;

   `ASSERT_ALWAYS(a_err_zero, !rsp_valid || rsp_data.status == STATUS_OK || (rsp_data.res_low == '0 && rsp_data.res_mid == '0 && rsp_data.res_high == '0 && rsp_data.res_scale == '0 && !rsp_data.res_sign), "overflow result carries nonzero fields")
   `ASSERT_ALWAYS(a_range, !rsp_valid || (rsp_data.res_scale <= 5'(MAX_SCALE) && rsp_data.status != 2'd3), "result scale or status out of range")
   `ASSERT_ALWAYS(a_zero_clean, !rsp_valid || rsp_data.res_low != '0 || rsp_data.res_mid != '0 || rsp_data.res_high != '0 || (rsp_data.res_scale == '0 && !rsp_data.res_sign), "zero result has scale or sign")
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind wide_decimal_round_to_96bit wdr_checker u_wdr_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wdr_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type rounded_queue[$];
   int      mismatches = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      overflow_count = 0;
   int      max_gap = 14;
   int      rsp_hold = 0;

   localparam logic [MANT_W-1:0] MAX96 = {{(MANT_W-RES_W){1'b0}}, {RES_W{1'b1}}};

   wide_decimal_round_to_96bit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type round_to_96(req_type r);
      logic [MANT_W-1:0] m;
      logic [MANT_W-1:0] digit;
      int      sc;
      logic    rnd;
      logic    sticky;
      rsp_type o;
      m = {r.mant_word6, r.mant_word5, r.mant_word4, r.mant_word3,
           r.mant_word2, r.mant_word1, r.mant_word0};
      sc = r.in_scale;
      rnd = 1'b0;
      sticky = 1'b0;
      o = '0;
      if (m == '0) return o;
      while ((m != '0 || rnd) &&
             (m[MANT_W-1:RES_W] != '0 || (m == MAX96 && rnd) || sc > MAX_SCALE)) begin
         digit = m % 10;
         m = m / 10;
         sc--;
         rnd = digit > 5 || (digit == 5 && (sticky || m[0]));
         if (digit != 0) sticky = 1'b1;
      end
      if (rnd) m = m + 1;
      if (sc < 0) begin
         o.status = r.in_sign ? STATUS_NEG_OVF : STATUS_POS_OVF;
         return o;
      end
      if (m[RES_W-1:0] == '0) return o;
      o.res_low = m[31:0];
      o.res_mid = m[63:32];
      o.res_high = m[95:64];
      o.res_scale = sc[4:0];
      o.res_sign = r.in_sign;
      o.status = STATUS_OK;
      return o;
   endfunction

   function automatic req_type make_req(logic [MANT_W-1:0] m, logic [7:0] sc, logic sg);
      req_type r;
      {r.mant_word6, r.mant_word5, r.mant_word4, r.mant_word3,
       r.mant_word2, r.mant_word1, r.mant_word0} = m;
      r.in_scale = sc;
      r.in_sign = sg;
      return r;
   endfunction

   function automatic logic [MANT_W-1:0] random_mant(int bits);
      logic [MANT_W-1:0] m;
      for (int i = 0; i < 7; i++) m[i*32 +: 32] = $urandom;
      if (bits < MANT_W) m = m & ((MANT_W'(1) << bits) - 1);
      return m;
   endfunction

   task automatic send_item(req_type r);
      int      gap;
      rsp_type expected;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected = round_to_96(r);
      rounded_queue.push_back(expected);
      if (expected.status != STATUS_OK) overflow_count++;
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (rounded_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected transaction: %p", rsp_data);
         end else begin
            if (rsp_data.res_low !== rounded_queue[0].res_low ||
                rsp_data.res_mid !== rounded_queue[0].res_mid ||
                rsp_data.res_high !== rounded_queue[0].res_high ||
                rsp_data.res_scale !== rounded_queue[0].res_scale ||
                rsp_data.res_sign !== rounded_queue[0].res_sign ||
                rsp_data.status !== rounded_queue[0].status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, actual %p", rounded_queue[0], rsp_data);
            end
            void'(rounded_queue.pop_front());
         end
         rsp_hold = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_directed();
      logic [MANT_W-1:0] all_ones;
      all_ones = '1;
      send_item(make_req('0, 8'd255, 1'b1));
      send_item(make_req('0, 8'd0, 1'b0));
      send_item(make_req(MAX96, 8'd0, 1'b0));
      send_item(make_req(MAX96, 8'd28, 1'b1));
      send_item(make_req(MAX96 + 1, 8'd28, 1'b0));
      send_item(make_req(all_ones, 8'd0, 1'b0));
      send_item(make_req(all_ones, 8'd0, 1'b1));
      send_item(make_req(all_ones, 8'd255, 1'b1));
      send_item(make_req(all_ones, 8'd68, 1'b0));
      send_item(make_req(MANT_W'(25), 8'd29, 1'b0));
      send_item(make_req(MANT_W'(35), 8'd29, 1'b1));
      send_item(make_req(MANT_W'(251), 8'd30, 1'b0));
      send_item(make_req(MANT_W'(250), 8'd30, 1'b0));
      send_item(make_req(MANT_W'(19), 8'd29, 1'b0));
      send_item(make_req(MANT_W'(14), 8'd29, 1'b1));
      send_item(make_req(MANT_W'(5), 8'd29, 1'b0));
      send_item(make_req(MANT_W'(6), 8'd29, 1'b1));
      send_item(make_req(MANT_W'(1), 8'd255, 1'b0));
      send_item(make_req(MAX96 * 10 + 5, 8'd5, 1'b0));
      send_item(make_req(MAX96 * 10 + 4, 8'd5, 1'b1));
      send_item(make_req(MAX96 * 10 + 9, 8'd0, 1'b0));
      send_item(make_req(MANT_W'(1) << 223, 8'd128, 1'b1));
   endtask

   task automatic test_random(int count);
      logic [MANT_W-1:0] m;
      logic [7:0] sc;
      int pick;
      int k;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            m = random_mant($urandom_range(1, 130));
            sc = 8'($urandom_range(0, 40));
         end else if (pick < 75) begin
            m = random_mant($urandom_range(130, MANT_W));
            sc = 8'($urandom_range(0, 90));
         end else if (pick < 80) begin
            m = random_mant($urandom_range(1, MANT_W));
            sc = 8'($urandom_range(128, 255));
         end else if (pick < 92) begin
            k = $urandom_range(1, 3);
            m = random_mant($urandom_range(1, 40));
            for (int j = 0; j < k; j++) m = m * 10;
            m = m + 5 * (k == 1 ? 1 : (k == 2 ? 10 : 100)) + ($urandom_range(0, 1) ? 0 : 1);
            sc = 8'(MAX_SCALE + k);
         end else begin
            m = MAX96 * 10 + $urandom_range(0, 9);
            sc = 8'($urandom_range(0, 30));
         end
         send_item(make_req(m, sc, 1'($urandom_range(0, 1))));
      end
   endtask

   task automatic test_no_idle(int count);
      max_gap = 0;
      test_random(count);
      max_gap = 14;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(800);
      test_no_idle(200);
      test_random(200);
      @(posedge clock);
      req_valid <= 1'b0;
      while (rounded_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d transactions, %0d results checked, %0d overflows.",
               sent_count, checked_count, overflow_count);
      if (mismatches == 0 && rounded_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("Mismatches: %0d", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #200000000;
      $display("Timed out with %0d results outstanding.", rounded_queue.size());
      $display("FAILURE");
      $finish;
   end

endmodule
